// ===== hw/rtl/sisu_pkg.sv =====
// Shared package for the sorted interval union store: capacity, widths,
// command and status codes, and the structs passed between the sequencer
// and the cell chain. It depends on nothing else.
package sisu_pkg;

  // Store geometry.
  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the beats.
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 6;

  typedef logic signed [DATA_W-1:0] coord_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_ADDED     = 3'd0,
    STATUS_COALESCED = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_DUMPED    = 3'd3,
    STATUS_EMPTY     = 3'd4
  } status_t;

  // Input command codes.
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DUMP   = 1'b1
  } cmd_t;

  // Operation broadcast to every cell in a cycle.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CMP,
    OP_ABSORB,
    OP_INSERT,
    OP_MERGE,
    OP_ROTATE
  } op_t;

  // Source of the span carried by a result beat.
  typedef enum logic [1:0] {
    SEL_NEW,
    SEL_FOCUS,
    SEL_HEAD,
    SEL_ZERO
  } sel_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_ACT,
    ST_MERGE,
    ST_RESULT,
    ST_DUMP
  } state_t;

  // Control broadcast from the sequencer to the cells.
  typedef struct packed {
    op_t              op;
    coord_t           lo;
    coord_t           hi;
    logic [CNT_W-1:0] count;
  } ctrl_t;

  // Summary flags gathered from the cells.
  typedef struct packed {
    logic any_ov;
    logic merge_any;
  } flags_t;

  // Request to load the result register.
  typedef struct packed {
    logic    fire;
    status_t status;
    sel_t    sel;
    logic    last;
  } emit_t;

endpackage

// ===== hw/rtl/sisu_cell.sv =====
// One cell of the interval chain: holds a single stored interval and the
// flags that locate it against the interval being inserted.
// Depends on sisu_pkg.
module sisu_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [sisu_pkg::IDX_W-1:0] idx,
  input  sisu_pkg::ctrl_t            ctrl,
  input  logic                       prev_nb,
  input  sisu_pkg::coord_t           left_lo,
  input  sisu_pkg::coord_t           left_hi,
  input  logic                       right_valid,
  input  sisu_pkg::coord_t           right_lo,
  input  sisu_pkg::coord_t           right_hi,
  input  sisu_pkg::coord_t           head_lo,
  input  sisu_pkg::coord_t           head_hi,
  output logic                       cell_valid,
  output logic                       nb,
  output logic                       focus,
  output logic                       ov_hit,
  output logic                       merge_hit,
  output sisu_pkg::coord_t           lo,
  output sisu_pkg::coord_t           hi
);
  import sisu_pkg::*;

  logic   after;
  logic   ov;
  logic   lt_lo;
  logic   gt_hi;
  logic   below;
  coord_t lo_next;
  coord_t hi_next;

  // The cell is occupied when its place lies below the fill count.
  assign cell_valid = CNT_W'(idx) < ctrl.count;

  // An occupied cell wholly below the new interval; the first cell that is
  // not below marks the insertion point.
  assign below = cell_valid && (hi < ctrl.lo);
  assign nb    = !below;

  // The focus cell reports an overlap, and whether its right neighbour
  // must fold into it.
  assign ov_hit    = focus && ov;
  assign merge_hit = focus && right_valid && (right_lo <= hi);

  // Data movement for the broadcast operation.
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    case (ctrl.op)
      OP_ABSORB: begin
        if (focus) begin
          lo_next = lt_lo ? ctrl.lo : lo;
          hi_next = gt_hi ? ctrl.hi : hi;
        end
      end
      OP_INSERT: begin
        if (focus) begin
          lo_next = ctrl.lo;
          hi_next = ctrl.hi;
        end else if (after) begin
          lo_next = left_lo;
          hi_next = left_hi;
        end
      end
      OP_MERGE: begin
        if (focus) begin
          hi_next = (right_hi > hi) ? right_hi : hi;
        end else if (after) begin
          lo_next = right_lo;
          hi_next = right_hi;
        end
      end
      OP_ROTATE: begin
        if (cell_valid) begin
          lo_next = right_valid ? right_lo : head_lo;
          hi_next = right_valid ? right_hi : head_hi;
        end
      end
      default: begin
        lo_next = lo;
        hi_next = hi;
      end
    endcase
  end

  // Interval storage.
  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
  end

  // Position flags, captured in the compare cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      focus <= 1'b0;
      after <= 1'b0;
    end else if (ctrl.op == OP_CMP) begin
      focus <= nb && !prev_nb;
      after <= prev_nb;
    end
  end

  // Compare results used by the absorb step.
  always_ff @(posedge clk) begin
    if (ctrl.op == OP_CMP) begin
      ov    <= cell_valid && (lo <= ctrl.hi);
      lt_lo <= ctrl.lo < lo;
      gt_hi <= ctrl.hi > hi;
    end
  end

endmodule

// ===== hw/rtl/sisu_seq.sv =====
// Sequencer of the interval store: input register, fill count, dump
// counter and the operation broadcast to the cell chain.
// Depends on sisu_pkg.
module sisu_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        command,
  input  logic signed [sisu_pkg::DATA_W-1:0] range_start,
  input  logic signed [sisu_pkg::DATA_W-1:0] range_end,
  input  sisu_pkg::flags_t            flags,
  input  logic                        out_free,
  output sisu_pkg::ctrl_t             ctrl,
  output sisu_pkg::emit_t             emit
);
  import sisu_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] dump_idx;
  logic [IDX_W-1:0] dump_idx_next;
  status_t          res_status;
  status_t          res_status_next;
  coord_t           new_lo;
  coord_t           new_hi;
  op_t              op;
  logic             in_accept;
  logic             dump_last;
  logic             store_full;

  assign in_accept  = in_valid && !in_stall;
  assign dump_last  = CNT_W'(dump_idx) == (count - CNT_W'(1));
  assign store_full = count == CNT_W'(CAPACITY);

  assign ctrl = '{op: op, lo: new_lo, hi: new_hi, count: count};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (command == CMD_DUMP) ? ST_DUMP : ST_CMP;
        end
      end
      ST_CMP: begin
        state_next = ST_ACT;
      end
      ST_ACT: begin
        state_next = flags.any_ov ? ST_MERGE : ST_RESULT;
      end
      ST_MERGE: begin
        if (!flags.merge_any) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (out_free && ((count == '0) || dump_last)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs and register next values.
  always_comb begin
    in_stall        = 1'b1;
    op              = OP_HOLD;
    emit            = '{fire: 1'b0, status: STATUS_ADDED, sel: SEL_NEW, last: 1'b1};
    count_next      = count;
    dump_idx_next   = dump_idx;
    res_status_next = res_status;
    case (state)
      ST_IDLE: begin
        in_stall      = rst;
        dump_idx_next = '0;
      end
      ST_CMP: begin
        op = OP_CMP;
      end
      ST_ACT: begin
        if (flags.any_ov) begin
          op              = OP_ABSORB;
          res_status_next = STATUS_COALESCED;
        end else if (store_full) begin
          res_status_next = STATUS_FULL;
        end else begin
          op              = OP_INSERT;
          count_next      = count + CNT_W'(1);
          res_status_next = STATUS_ADDED;
        end
      end
      ST_MERGE: begin
        if (flags.merge_any) begin
          op         = OP_MERGE;
          count_next = count - CNT_W'(1);
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          emit.fire   = 1'b1;
          emit.status = res_status;
          emit.sel    = (res_status == STATUS_COALESCED) ? SEL_FOCUS : SEL_NEW;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          emit.fire = 1'b1;
          if (count == '0) begin
            emit.status = STATUS_EMPTY;
            emit.sel    = SEL_ZERO;
          end else begin
            emit.status   = STATUS_DUMPED;
            emit.sel      = SEL_HEAD;
            emit.last     = dump_last;
            op            = OP_ROTATE;
            dump_idx_next = dump_idx + IDX_W'(1);
          end
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      dump_idx   <= '0;
      res_status <= STATUS_ADDED;
    end else begin
      state      <= state_next;
      count      <= count_next;
      dump_idx   <= dump_idx_next;
      res_status <= res_status_next;
    end
  end

  // The accepted interval, endpoints put in order.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      new_lo <= (range_start < range_end) ? range_start : range_end;
      new_hi <= (range_start < range_end) ? range_end : range_start;
    end
  end

endmodule

// ===== hw/rtl/sorted_interval_union_store_unit.sv =====
// Top level of the sorted interval union store: the sequencer, the chain
// of interval cells and the result register.
// Depends on sisu_pkg, sisu_seq and sisu_cell.
//
// Usage. The input channel carries a command with two signed endpoints.
// An insert orders the endpoints, coalesces every stored interval that
// shares a point with the new one, or places it in sorted position, and
// returns one beat with the resulting span and the new count. An insert
// that needs a slot in a full store is dropped with a full status. A dump
// returns one beat per stored interval in ascending order, the final one
// marked by last, or a single empty-status beat when nothing is stored.
// Timing. The block takes one command at a time. An insert passes through
// the compare state, then the act state, which absorbs, places or drops
// the new interval, and then the result state, which loads its result
// beat; one that coalesces passes through the merge state between the act
// and result states, where the chain folds one neighbour into the focus
// cell per cycle until nothing more folds. A dump loads one beat per cycle
// while the result channel does not stall, and the block can take the next
// command once the final beat is loaded: the chain rotates by one cell per
// beat and every beat is read from the head cell. A stall on the result
// channel holds the beat in the output register and pauses the sequencer
// before the next beat. Reset empties the store at once and needs no
// clearing pass; the block accepts a command in the cycle after reset.
module sorted_interval_union_store_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 command,
  input  logic signed [sisu_pkg::DATA_W-1:0]   range_start,
  input  logic signed [sisu_pkg::DATA_W-1:0]   range_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sisu_pkg::STATUS_W-1:0]        status,
  output logic signed [sisu_pkg::DATA_W-1:0]   span_low,
  output logic signed [sisu_pkg::DATA_W-1:0]   span_high,
  output logic [sisu_pkg::COUNT_W-1:0]         entry_count,
  output logic                                 last
);
  import sisu_pkg::*;

  ctrl_t                ctrl;
  emit_t                emit;
  flags_t               flags;
  logic                 out_free;
  logic [CAPACITY-1:0]  valid_vec;
  logic [CAPACITY-1:0]  nb_vec;
  logic [CAPACITY-1:0]  focus_vec;
  logic [CAPACITY-1:0]  ov_vec;
  logic [CAPACITY-1:0]  merge_vec;
  coord_t               cell_lo [CAPACITY];
  coord_t               cell_hi [CAPACITY];
  coord_t               focus_lo;
  coord_t               focus_hi;
  coord_t               res_lo;
  coord_t               res_hi;

  // The result register can take a beat when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  sisu_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .range_start (range_start),
    .range_end   (range_end),
    .flags       (flags),
    .out_free    (out_free),
    .ctrl        (ctrl),
    .emit        (emit)
  );

  // The chain of cells, each wired to its two neighbours and the head.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic   prev_nb;
    coord_t left_lo;
    coord_t left_hi;
    logic   right_valid;
    coord_t right_lo;
    coord_t right_hi;

    if (g == 0) begin : g_first
      assign prev_nb = 1'b0;
      assign left_lo = '0;
      assign left_hi = '0;
    end else begin : g_inner_left
      assign prev_nb = nb_vec[g-1];
      assign left_lo = cell_lo[g-1];
      assign left_hi = cell_hi[g-1];
    end

    if (g == CAPACITY - 1) begin : g_end
      assign right_valid = 1'b0;
      assign right_lo    = '0;
      assign right_hi    = '0;
    end else begin : g_inner_right
      assign right_valid = valid_vec[g+1];
      assign right_lo    = cell_lo[g+1];
      assign right_hi    = cell_hi[g+1];
    end

    sisu_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .idx         (IDX_W'(g)),
      .ctrl        (ctrl),
      .prev_nb     (prev_nb),
      .left_lo     (left_lo),
      .left_hi     (left_hi),
      .right_valid (right_valid),
      .right_lo    (right_lo),
      .right_hi    (right_hi),
      .head_lo     (cell_lo[0]),
      .head_hi     (cell_hi[0]),
      .cell_valid  (valid_vec[g]),
      .nb          (nb_vec[g]),
      .focus       (focus_vec[g]),
      .ov_hit      (ov_vec[g]),
      .merge_hit   (merge_vec[g]),
      .lo          (cell_lo[g]),
      .hi          (cell_hi[g])
    );
  end

  // Flags gathered from the chain; only the focus cell can raise them.
  assign flags = '{any_ov: |ov_vec, merge_any: |merge_vec};

  // Read the focus cell through a one-hot select.
  always_comb begin
    focus_lo = '0;
    focus_hi = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      focus_lo = focus_lo | ({DATA_W{focus_vec[k]}} & cell_lo[k]);
      focus_hi = focus_hi | ({DATA_W{focus_vec[k]}} & cell_hi[k]);
    end
  end

  // Span carried by the next result beat.
  always_comb begin
    case (emit.sel)
      SEL_NEW: begin
        res_lo = ctrl.lo;
        res_hi = ctrl.hi;
      end
      SEL_FOCUS: begin
        res_lo = focus_lo;
        res_hi = focus_hi;
      end
      SEL_HEAD: begin
        res_lo = cell_lo[0];
        res_hi = cell_hi[0];
      end
      default: begin
        res_lo = '0;
        res_hi = '0;
      end
    endcase
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (emit.fire) begin
      status      <= emit.status;
      span_low    <= res_lo;
      span_high   <= res_hi;
      entry_count <= COUNT_W'(ctrl.count);
      last        <= emit.last;
    end
  end

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.count <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  // At most one cell marks the insertion point.
  a_focus_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(focus_vec))
    else $error("more than one focus cell");

  // After a command is taken the block is busy until it is finished.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("command accepted while busy");

  // A beat is loaded only when the result register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit.fire |-> out_free)
    else $error("result beat overwritten");

  // The empty-store beat is the only one of its dump and reports no entries.
  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_EMPTY)) |-> (last && (entry_count == '0)))
    else $error("malformed empty-store beat");

endmodule
